// File: design/alsplit_pkg.sv
// Shared types, constants and helper functions for the address list splitter.
// Used by every module of the block; depends on nothing else.
package alsplit_pkg;

    // Fixed field widths
    localparam int BYTE_W  = 8;
    localparam int START_W = 12;
    localparam int LEN_W   = 13;
    localparam int POS_W   = 13;

    // Longest list that is parsed; later bytes only saturate the position
    localparam int MAX_LIST_BYTES = 4096;
    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_LIST_BYTES);

    // Default nesting limit for parenthesised comments
    localparam int MAX_COMMENT_DEPTH = 15;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Special characters
    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_OPEN   = 8'h28;
    localparam logic [BYTE_W-1:0] CH_CLOSE  = 8'h29;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2C;

    // Status codes on the end marker
    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_UNMATCHED   = 2'd1,
        ST_UNTERMINATED = 2'd2,
        ST_TOO_LONG    = 2'd3
    } t_status;

    // One result word
    typedef struct packed {
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
        logic               holds;
        logic               done;
        t_status            status;
    } t_result;

    // One queue entry: the results caused by one text byte
    typedef struct packed {
        t_result res0;
        t_result res1;
        logic    two;
    } t_entry;

    // Whitespace class of a Latin-1 byte
    function automatic logic is_blank(input logic [BYTE_W-1:0] c);
        return (c >= 8'd9 && c <= 8'd13) || c == 8'h20 || c == 8'h85 || c == 8'hA0;
    endfunction

    // A segment result from the trimming state
    function automatic t_result seg_result(input logic               saw,
                                           input logic [START_W-1:0] first,
                                           input logic [START_W-1:0] last,
                                           input logic [POS_W-1:0]   origin,
                                           input logic               done);
        t_result r;
        r.holds  = 1'b1;
        r.done   = done;
        r.status = ST_OK;
        if (saw) begin
            r.start  = first;
            r.length = LEN_W'({1'b0, last}) - LEN_W'({1'b0, first}) + LEN_W'(1);
        end else begin
            r.start  = origin[START_W-1:0];
            r.length = '0;
        end
        return r;
    endfunction

    // A bare end marker
    function automatic t_result end_marker(input t_status status);
        t_result r;
        r.start  = '0;
        r.length = '0;
        r.holds  = 1'b0;
        r.done   = 1'b1;
        r.status = status;
        return r;
    endfunction

endpackage

// File: design/alsplit_front.sv
// Front end of the splitter: takes one text byte a cycle while i_take is set, tracks quotes,
// comments, escapes and trimming, and pushes the results it causes.
// Depends on alsplit_pkg.
module alsplit_front import alsplit_pkg::*; #(
    parameter int MAX_DEPTH = MAX_COMMENT_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [BYTE_W-1:0] i_text_byte,
    input  logic              i_final_byte,
    output logic              o_push,
    output t_entry            o_entry
);

    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam logic [DEPTH_W-1:0] DEPTH_LIMIT = DEPTH_W'(MAX_DEPTH);

    logic               r_quote, n_quote;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic               r_skip, n_skip;
    logic               r_halted, n_halted;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [POS_W-1:0]   r_origin, n_origin;
    logic [START_W-1:0] r_first, n_first;
    logic [START_W-1:0] r_last, n_last;
    logic               r_saw, n_saw;

    logic    part;
    logic    have0;
    t_result res0, res1, fin_res;

    // Per-byte update of the parse state and the results of this byte
    always_comb begin
        n_quote  = r_quote;
        n_depth  = r_depth;
        n_skip   = r_skip;
        n_halted = r_halted;
        n_pos    = r_pos;
        n_origin = r_origin;
        n_first  = r_first;
        n_last   = r_last;
        n_saw    = r_saw;
        part     = 1'b1;
        have0    = 1'b0;
        res0     = '0;
        res1     = '0;
        fin_res  = '0;

        if (r_halted) begin
            // Ignore everything until the final byte.
        end else if (r_pos >= MAX_POS) begin
            n_pos = MAX_POS + POS_W'(1);
        end else begin
            if (r_skip) begin
                n_skip = 1'b0;
            end else begin
                unique case (i_text_byte)
                    CH_QUOTE: begin
                        if (r_depth == '0) n_quote = ~r_quote;
                    end
                    CH_OPEN: begin
                        if (!r_quote && r_depth < DEPTH_LIMIT) n_depth = r_depth + DEPTH_W'(1);
                    end
                    CH_CLOSE: begin
                        if (!r_quote) begin
                            if (r_depth != '0) begin
                                n_depth = r_depth - DEPTH_W'(1);
                            end else begin
                                n_halted = 1'b1;
                                part     = 1'b0;
                            end
                        end
                    end
                    CH_BSLASH: begin
                        n_skip = 1'b1;
                    end
                    CH_COMMA: begin
                        if (!r_quote && r_depth == '0) begin
                            part = 1'b0;
                            if (r_pos > r_origin) begin
                                res0  = seg_result(r_saw, r_first, r_last, r_origin, 1'b0);
                                have0 = 1'b1;
                            end
                            n_origin = r_pos + POS_W'(1);
                            n_saw    = 1'b0;
                            n_first  = '0;
                            n_last   = '0;
                        end
                    end
                    default: ;
                endcase
            end
            // Non-blank bytes move the trimmed bounds of the segment.
            if (part && !n_halted && !is_blank(i_text_byte)) begin
                if (!n_saw) begin
                    n_first = r_pos[START_W-1:0];
                    n_saw   = 1'b1;
                end
                n_last = r_pos[START_W-1:0];
            end
            n_pos = r_pos + POS_W'(1);
        end

        // The final byte closes the list and returns to the reset state.
        if (i_final_byte) begin
            if (n_halted) begin
                fin_res = end_marker(ST_UNMATCHED);
            end else if (n_pos > MAX_POS) begin
                fin_res = end_marker(ST_TOO_LONG);
            end else if (n_quote || n_depth != '0) begin
                fin_res = end_marker(ST_UNTERMINATED);
            end else if (n_pos > n_origin) begin
                fin_res = seg_result(n_saw, n_first, n_last, n_origin, 1'b1);
            end else begin
                fin_res = end_marker(ST_OK);
            end
            if (have0) res1 = fin_res;
            else       res0 = fin_res;
            n_quote  = 1'b0;
            n_depth  = '0;
            n_skip   = 1'b0;
            n_halted = 1'b0;
            n_pos    = '0;
            n_origin = '0;
            n_first  = '0;
            n_last   = '0;
            n_saw    = 1'b0;
        end
    end

    // Queue push for a byte that causes at least one result
    assign o_push        = i_take && (have0 || i_final_byte);
    assign o_entry.res0  = res0;
    assign o_entry.res1  = res1;
    assign o_entry.two   = have0 && i_final_byte;

    // Parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quote  <= 1'b0;
            r_depth  <= '0;
            r_skip   <= 1'b0;
            r_halted <= 1'b0;
            r_pos    <= '0;
            r_origin <= '0;
            r_first  <= '0;
            r_last   <= '0;
            r_saw    <= 1'b0;
        end else if (i_take) begin
            r_quote  <= n_quote;
            r_depth  <= n_depth;
            r_skip   <= n_skip;
            r_halted <= n_halted;
            r_pos    <= n_pos;
            r_origin <= n_origin;
            r_first  <= n_first;
            r_last   <= n_last;
            r_saw    <= n_saw;
        end
    end

endmodule

// File: design/alsplit_queue.sv
// Short first-in first-out queue of result entries between front and back.
// Depends on alsplit_pkg.
module alsplit_queue import alsplit_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output t_entry o_entry,
    output logic   o_full,
    output logic   o_empty
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_entry             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_entry;
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : r_wr_ptr + PTR_W'(1);
            if (i_pop)  r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                         : r_rd_ptr + PTR_W'(1);
            if (i_push && !i_pop)      r_count <= r_count + CNT_W'(1);
            else if (!i_push && i_pop) r_count <= r_count - CNT_W'(1);
        end
    end

endmodule

// File: design/alsplit_back.sv
// Back end of the splitter: unpacks queue entries into single result words
// and holds them in the output register. Depends on alsplit_pkg.
module alsplit_back import alsplit_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  t_entry             i_q_entry,
    output logic               o_pop,
    output logic               o_result_valid,
    input  logic               i_result_ready,
    output logic [START_W-1:0] o_segment_start,
    output logic [LEN_W-1:0]   o_segment_length,
    output logic               o_holds_address,
    output logic               o_list_done,
    output logic [1:0]         o_split_status
);

    logic    r_out_valid;
    t_result r_out;
    logic    r_pend_valid;
    t_result r_pend;
    logic    out_free;

    // The output register can load when empty or being taken this cycle.
    assign out_free = !r_out_valid || i_result_ready;
    assign o_pop    = out_free && !r_pend_valid && !i_q_empty;

    // Control: output valid and the pending second word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_pend_valid <= 1'b0;
        end else if (out_free) begin
            if (r_pend_valid) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= 1'b0;
            end else begin
                r_out_valid  <= !i_q_empty;
                r_pend_valid <= !i_q_empty && i_q_entry.two;
            end
        end
    end

    // Payload of the output and pending words
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_pend_valid) begin
                r_out <= r_pend;
            end else if (!i_q_empty) begin
                r_out  <= i_q_entry.res0;
                r_pend <= i_q_entry.res1;
            end
        end
    end

    assign o_result_valid   = r_out_valid;
    assign o_segment_start  = r_out.start;
    assign o_segment_length = r_out.length;
    assign o_holds_address  = r_out.holds;
    assign o_list_done      = r_out.done;
    assign o_split_status   = r_out.status;

endmodule

// File: design/address_list_splitter.sv
// Top level of the address list splitter: front parser, result queue and
// output stage. Depends on alsplit_pkg, alsplit_front, alsplit_queue, alsplit_back.
//
//   Channel   Direction  Handshake                       Word
//   text      in         i_text_valid / o_text_ready     i_text_byte, i_final_byte
//   result    out        o_result_valid / i_result_ready o_segment_start, o_segment_length,
//                                                        o_holds_address, o_list_done,
//                                                        o_split_status
//
// One text word is taken every cycle while the queue has room; the parse state
// update is flag and counter logic in the front end.
// A word's results are registered in the queue and then in the output register.
// The output stage holds the second result of a word in a pending register.
// Reset is synchronous and active low and clears all parse and queue state.
// When the result side stalls the queue fills and o_text_ready then falls.
module address_list_splitter import alsplit_pkg::*; #(
    parameter int MAX_DEPTH = MAX_COMMENT_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_text_valid,
    output logic               o_text_ready,
    input  logic [BYTE_W-1:0]  i_text_byte,
    input  logic               i_final_byte,
    output logic               o_result_valid,
    input  logic               i_result_ready,
    output logic [START_W-1:0] o_segment_start,
    output logic [LEN_W-1:0]   o_segment_length,
    output logic               o_holds_address,
    output logic               o_list_done,
    output logic [1:0]         o_split_status
);

    logic   take;
    logic   push;
    logic   pop;
    logic   q_full;
    logic   q_empty;
    t_entry push_entry;
    t_entry head_entry;

    assign o_text_ready = !q_full;
    assign take         = i_text_valid && o_text_ready;

    // Parser
    alsplit_front #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_text_byte  (i_text_byte),
        .i_final_byte (i_final_byte),
        .o_push       (push),
        .o_entry      (push_entry)
    );

    // Result queue
    alsplit_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Output stage
    alsplit_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .i_q_entry        (head_entry),
        .o_pop            (pop),
        .o_result_valid   (o_result_valid),
        .i_result_ready   (i_result_ready),
        .o_segment_start  (o_segment_start),
        .o_segment_length (o_segment_length),
        .o_holds_address  (o_holds_address),
        .o_list_done      (o_list_done),
        .o_split_status   (o_split_status)
    );

endmodule
